// File: design/rbei_pkg.sv
// shared types, codes and saturation helpers for the rigid body integrator
package rbei_pkg;

  localparam logic [2:0] FUNC_FORCE   = 3'd0;
  localparam logic [2:0] FUNC_GRAVITY = 3'd1;
  localparam logic [2:0] FUNC_STEP    = 3'd2;
  localparam logic [2:0] FUNC_SET_POS = 3'd3;
  localparam logic [2:0] FUNC_SET_VEL = 3'd4;

  localparam logic [2:0] CFG_MASS    = 3'd0;
  localparam logic [2:0] CFG_DYNAMIC = 3'd1;
  localparam logic [2:0] CFG_DAMPING = 3'd2;
  localparam logic [2:0] CFG_EPSILON = 3'd3;
  localparam logic [2:0] CFG_BOUND   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FORCE,
    OP_GRAVITY,
    OP_STEP,
    OP_SET_POS,
    OP_SET_VEL
  } op_t;

  typedef struct packed {
    logic [30:0]        mass;
    logic               dynamic;
    logic [30:0]        damping;
    logic [15:0]        epsilon;
    logic signed [31:0] bound;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        dt;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [31:0] sat32_49(input logic signed [48:0] v);
    if (v[48:31] == {18{v[48]}}) begin
      return v[31:0];
    end
    return v[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  // product shifted right by 16 with floor rounding, then saturated
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    return sat32_49({p[63], p[63:16]});
  endfunction

endpackage

// File: design/rbei_queue.sv
// two-entry item queue between the front and back of the integrator
module rbei_queue
  import rbei_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     item_in,
  input  logic      pop,
  output item_t     item_out,
  output q_status_t status
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  assign item_out     = mem[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

// File: design/rbei_front.sv
// front end: takes items and classifies them into back-end operations
module rbei_front
  import rbei_pkg::*;
(
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic [30:0]        delta_time,
  input  cfg_t               cfg,
  input  q_status_t          q_status,
  output logic               q_push,
  output item_t              q_item
);

  logic can_push;

  assign can_push = cfg.dynamic && (cfg.mass != 31'd0) && (cfg.mass >= {15'd0, cfg.epsilon});

  always_comb begin
    q_item.vx = value_x;
    q_item.vy = value_y;
    q_item.dt = delta_time;
    unique case (func)
      FUNC_FORCE:   q_item.op = can_push ? OP_FORCE : OP_NOP;
      FUNC_GRAVITY: q_item.op = can_push ? OP_GRAVITY : OP_NOP;
      FUNC_STEP:    q_item.op = cfg.dynamic ? OP_STEP : OP_NOP;
      FUNC_SET_POS: q_item.op = OP_SET_POS;
      FUNC_SET_VEL: q_item.op = OP_SET_VEL;
      default:      q_item.op = OP_NOP;
    endcase
  end

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

endmodule

// File: design/rbei_back.sv
// back end: body state, shared multiplier, serial divider and result register
module rbei_back
  import rbei_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               cfg_clear,
  input  item_t              q_item,
  input  q_status_t          q_status,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic               position_changed,
  output logic               left_bounds,
  output logic               deletion_mark
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_DIV    = 5'b00100,
    S_STEP   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t             state;
  op_t                op;
  logic signed [31:0] wvx, wvy;
  logic [30:0]        wdt;
  logic signed [31:0] px, py, vx, vy, ax, ay;
  logic               marked;
  logic signed [31:0] factor;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;
  logic [5:0]         cnt;
  logic               comp;
  logic               neg;
  logic [31:0]        rem;
  logic [47:0]        quo;
  logic [31:0]        rem_sh;
  logic               ge;
  logic               left;
  logic               out_free;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic n, input logic [47:0] m);
    logic signed [48:0] v;
    v = $signed({1'b0, m});
    return sat32_49(n ? -v : v);
  endfunction

  assign q_pop    = (state == S_IDLE) && !q_status.empty;
  assign out_free = !out_valid || !out_stall;
  assign rem_sh   = {rem[30:0], quo[47]};
  assign ge       = rem_sh >= {1'b0, cfg.mass};
  assign left     = (op == OP_STEP) && (py > cfg.bound);

  always_comb begin
    case (cnt[2:0])
      3'd0: begin
        mul_a = $signed({1'b0, cfg.damping});
        mul_b = $signed({1'b0, wdt});
      end
      3'd1: begin
        mul_a = ax;
        mul_b = $signed({1'b0, wdt});
      end
      3'd2: begin
        mul_a = ay;
        mul_b = $signed({1'b0, wdt});
      end
      3'd3: begin
        mul_a = vx;
        mul_b = factor;
      end
      3'd4: begin
        mul_a = vy;
        mul_b = factor;
      end
      3'd5: begin
        mul_a = vx;
        mul_b = $signed({1'b0, wdt});
      end
      3'd6: begin
        mul_a = vy;
        mul_b = $signed({1'b0, wdt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      deletion_mark <= 1'b0;
      marked        <= 1'b0;
      px            <= '0;
      py            <= '0;
      vx            <= '0;
      vy            <= '0;
      ax            <= '0;
      ay            <= '0;
      cnt           <= '0;
      comp          <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            op    <= q_item.op;
            wvx   <= q_item.vx;
            wvy   <= q_item.vy;
            wdt   <= q_item.dt;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt <= '0;
          case (op)
            OP_FORCE: begin
              neg   <= wvx[31];
              quo   <= {mag32(wvx), 16'd0};
              rem   <= '0;
              comp  <= 1'b0;
              state <= S_DIV;
            end
            OP_GRAVITY: begin
              ax    <= qadd(ax, wvx);
              ay    <= qadd(ay, wvy);
              state <= S_FINISH;
            end
            OP_STEP: begin
              state <= S_STEP;
            end
            OP_SET_POS: begin
              px    <= wvx;
              py    <= wvy;
              state <= S_FINISH;
            end
            OP_SET_VEL: begin
              vx    <= wvx;
              vy    <= wvy;
              state <= S_FINISH;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_DIV: begin
          if (cnt != 6'd48) begin
            rem <= ge ? rem_sh - {1'b0, cfg.mass} : rem_sh;
            quo <= {quo[46:0], ge};
            cnt <= cnt + 6'd1;
          end else if (!comp) begin
            ax   <= qadd(ax, sat_mag(neg, quo));
            neg  <= wvy[31];
            quo  <= {mag32(wvy), 16'd0};
            rem  <= '0;
            cnt  <= '0;
            comp <= 1'b1;
          end else begin
            ay    <= qadd(ay, sat_mag(neg, quo));
            state <= S_FINISH;
          end
        end
        S_STEP: begin
          cnt <= cnt + 6'd1;
          case (cnt[2:0])
            3'd1: factor <= sat32_49(49'sd65536 - $signed({1'b0, prod[63:16]}));
            3'd2: vx <= qadd(vx, qscale(prod));
            3'd3: vy <= qadd(vy, qscale(prod));
            3'd4: vx <= qscale(prod);
            3'd5: vy <= qscale(prod);
            3'd6: px <= qadd(px, qscale(prod));
            3'd7: begin
              py    <= qadd(py, qscale(prod));
              ax    <= '0;
              ay    <= '0;
              state <= S_FINISH;
            end
            default: ;
          endcase
        end
        S_FINISH: begin
          if (out_free) begin
            pos_x            <= px;
            pos_y            <= py;
            vel_x            <= vx;
            vel_y            <= vy;
            position_changed <= (op == OP_STEP) || (op == OP_SET_POS);
            left_bounds      <= left;
            deletion_mark    <= marked || left;
            marked           <= marked || left;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_clear) begin
        vx <= '0;
        vy <= '0;
        ax <= '0;
        ay <= '0;
      end
    end
  end

endmodule

// File: design/rigid_body_euler_integrator.sv
// top level of the 2d rigid body semi-implicit euler integrator
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     func, value_x, value_y, delta_time
//   out      output     out_valid / out_stall   pos_x, pos_y, vel_x, vel_y, flags
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// a time step runs its products through slots of the one 32x32 multiplier, and a
// force runs two 48-step restoring divisions by the mass, one bit per cycle.
// rst is synchronous; it clears the body state and queue and loads the config defaults.
// a two-entry queue lets new items in while a result waits under out_stall.
module rigid_body_euler_integrator
  import rbei_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic [30:0]        delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic               position_changed,
  output logic               left_bounds,
  output logic               deletion_mark,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t      cfg;
  logic      cfg_clear;
  logic      q_push;
  logic      q_pop;
  item_t     q_in;
  item_t     q_out;
  q_status_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass    <= 31'd655360;
      cfg.dynamic <= 1'b1;
      cfg.damping <= 31'd6554;
      cfg.epsilon <= 16'd7;
      cfg.bound   <= 32'sd65536000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASS:    cfg.mass    <= cfg_data[30:0];
        CFG_DYNAMIC: cfg.dynamic <= cfg_data[0];
        CFG_DAMPING: cfg.damping <= cfg_data[30:0];
        CFG_EPSILON: cfg.epsilon <= cfg_data[15:0];
        CFG_BOUND:   cfg.bound   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we && (cfg_index == CFG_DYNAMIC) && !cfg_data[0];

  rbei_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .value_x    (value_x),
    .value_y    (value_y),
    .delta_time (delta_time),
    .cfg        (cfg),
    .q_status   (q_stat),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  rbei_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .status   (q_stat)
  );

  rbei_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cfg_clear        (cfg_clear),
    .q_item           (q_out),
    .q_status         (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .vel_x            (vel_x),
    .vel_y            (vel_y),
    .position_changed (position_changed),
    .left_bounds      (left_bounds),
    .deletion_mark    (deletion_mark)
  );

  a_left_implies_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_bounds |-> position_changed && deletion_mark)
    else $error("left_bounds without position_changed and deletion_mark");

  a_mark_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(deletion_mark) |-> deletion_mark)
    else $error("deletion_mark cleared without reset");

  a_item_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !q_stat.empty)
    else $error("accepted item missing from queue");

endmodule

// File: tb/sv/tb_rigid_body_euler_integrator.sv
// testbench for rigid_body_euler_integrator: directed and random items checked against a body model
module tb_rigid_body_euler_integrator
  import rbei_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 200;
  localparam logic [2:0] FUNC_UNUSED_LO = FUNC_SET_VEL + 3'd1;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               changed;
    logic               left;
    logic               mark;
  } body_view_t;

  class body_motion;
    logic [30:0]        mass;
    logic               dyn;
    logic [30:0]        damp;
    logic [15:0]        eps;
    logic signed [31:0] bound;
    logic signed [31:0] px, py, vx, vy, ax, ay;
    logic               mark;
    body_view_t         states_due[$];
    int                 errors;

    function new();
      mass = 31'd655360;
      dyn = 1'b1;
      damp = 31'd6554;
      eps = 16'd7;
      bound = 32'sd65536000;
      px = 0;
      py = 0;
      vx = 0;
      vy = 0;
      ax = 0;
      ay = 0;
      mark = 1'b0;
      errors = 0;
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function logic signed [31:0] mul_q(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat(p >>> 16);
    endfunction

    function logic signed [31:0] add_q(logic signed [31:0] a, logic signed [31:0] b);
      return sat(longint'(a) + longint'(b));
    endfunction

    function void take_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_MASS: mass = data[30:0];
        CFG_DYNAMIC: begin
          dyn = data[0];
          if (!dyn) begin
            vx = 0;
            vy = 0;
            ax = 0;
            ay = 0;
          end
        end
        CFG_DAMPING: damp = data[30:0];
        CFG_EPSILON: eps = data[15:0];
        CFG_BOUND: bound = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] fn, logic signed [31:0] x, logic signed [31:0] y,
                            logic [30:0] dt);
      body_view_t         r;
      logic               push;
      longint             m;
      longint             dprod;
      logic signed [31:0] factor;
      logic signed [31:0] dts;
      push = dyn && mass != 0 && mass >= eps;
      m = longint'(mass);
      dts = {1'b0, dt};
      r.changed = 1'b0;
      r.left = 1'b0;
      case (fn)
        FUNC_FORCE: begin
          if (push) begin
            ax = add_q(ax, sat(longint'(x) * 65536 / m));
            ay = add_q(ay, sat(longint'(y) * 65536 / m));
          end
        end
        FUNC_GRAVITY: begin
          if (push) begin
            ax = add_q(ax, x);
            ay = add_q(ay, y);
          end
        end
        FUNC_STEP: begin
          if (dyn) begin
            dprod = (longint'(damp) * longint'(dt)) >>> 16;
            factor = sat(64'sd65536 - dprod);
            vx = add_q(vx, mul_q(ax, dts));
            vy = add_q(vy, mul_q(ay, dts));
            vx = mul_q(vx, factor);
            vy = mul_q(vy, factor);
            px = add_q(px, mul_q(vx, dts));
            py = add_q(py, mul_q(vy, dts));
            ax = 0;
            ay = 0;
            r.changed = 1'b1;
            if (py > bound) begin
              r.left = 1'b1;
              mark = 1'b1;
            end
          end
        end
        FUNC_SET_POS: begin
          px = x;
          py = y;
          r.changed = 1'b1;
        end
        FUNC_SET_VEL: begin
          vx = x;
          vy = y;
        end
        default: ;
      endcase
      r.px = px;
      r.py = py;
      r.vx = vx;
      r.vy = vy;
      r.mark = mark;
      states_due.insert(states_due.size(), r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %h, expected %h", what, got, want);
    endfunction

    function void check_result(body_view_t got);
      body_view_t want;
      if (states_due.size() == 0) begin
        report("result with nothing expected", got.px, 32'd0);
        return;
      end
      want = states_due.pop_front();
      if (got.px !== want.px) report("pos_x", got.px, want.px);
      if (got.py !== want.py) report("pos_y", got.py, want.py);
      if (got.vx !== want.vx) report("vel_x", got.vx, want.vx);
      if (got.vy !== want.vy) report("vel_y", got.vy, want.vy);
      if (got.changed !== want.changed) report("position_changed", got.changed, want.changed);
      if (got.left !== want.left) report("left_bounds", got.left, want.left);
      if (got.mark !== want.mark) report("deletion_mark", got.mark, want.mark);
    endfunction

    function int pending();
      return states_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         func = FUNC_FORCE;
  logic signed [31:0] value_x = 0;
  logic signed [31:0] value_y = 0;
  logic [30:0]        delta_time = 0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic               position_changed, left_bounds, deletion_mark;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_MASS;
  logic [31:0]        cfg_data = 0;

  body_motion motion = new();
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_len = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rigid_body_euler_integrator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .value_x(value_x),
    .value_y(value_y),
    .delta_time(delta_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .position_changed(position_changed),
    .left_bounds(left_bounds),
    .deletion_mark(deletion_mark),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rigid_body_euler_integrator: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      motion.check_result('{pos_x, pos_y, vel_x, vel_y,
                            position_changed, left_bounds, deletion_mark});
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic offer(logic [2:0] fn, logic signed [31:0] x, logic signed [31:0] y,
                       logic [30:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    value_x <= x;
    value_y <= y;
    delta_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    motion.note_item(fn, x, y, dt);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (motion.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    motion.take_register(idx, data);
    @(posedge clk);
  endtask

  task automatic set_mass(logic [30:0] m);
    set_register(CFG_MASS, {1'($urandom_range(1)), m});
  endtask

  task automatic set_damping(logic [30:0] d);
    set_register(CFG_DAMPING, {1'($urandom_range(1)), d});
  endtask

  task automatic set_dynamic(logic d);
    set_register(CFG_DYNAMIC, {31'($urandom), d});
  endtask

  task automatic set_epsilon(logic [15:0] e);
    set_register(CFG_EPSILON, {16'($urandom), e});
  endtask

  task automatic apply_phase(int k);
    case (k)
      0: ;
      1: begin
        set_mass(31'd65536);
        set_dynamic(1'b1);
        set_damping(31'd0);
        set_epsilon(16'd0);
        set_register(CFG_BOUND, 32'd0);
      end
      2: begin
        set_mass(31'h7fff_ffff);
        set_damping(31'h7fff_ffff);
        set_epsilon(16'hffff);
        set_register(CFG_BOUND, 32'h7fff_ffff);
      end
      3: begin
        set_mass(31'd3);
        set_epsilon(16'd100);
        set_damping(31'd6554);
        set_register(CFG_BOUND, 32'h8000_0000);
      end
      4: begin
        set_mass(31'd0);
        set_epsilon(16'd0);
        set_register(CFG_BOUND, 32'd6553600);
      end
      5: set_dynamic(1'b0);
      6: begin
        set_dynamic(1'b1);
        set_mass(31'd131072);
        set_damping(31'd6554);
        set_epsilon(16'd7);
        set_register(CFG_BOUND, 32'd6553600);
      end
      default: begin
        set_mass(31'($urandom_range(1 << 22)));
        set_dynamic(1'b1);
        set_damping(31'($urandom_range(131072)));
        set_epsilon(16'($urandom));
        set_register(CFG_BOUND, $urandom);
      end
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return int'($urandom_range(1048576)) - 524288;
    if (pick < 85) return $urandom;
    case ($urandom_range(4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 31'($urandom_range(65536));
    if (pick < 80) return 31'd0;
    if (pick < 90) return 31'($urandom);
    return 31'h7fff_ffff;
  endfunction

  function automatic logic [2:0] rand_func();
    int pick;
    pick = $urandom_range(99);
    if (pick < 18) return FUNC_FORCE;
    if (pick < 38) return FUNC_GRAVITY;
    if (pick < 72) return FUNC_STEP;
    if (pick < 82) return FUNC_SET_POS;
    if (pick < 93) return FUNC_SET_VEL;
    return 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
  endfunction

  initial begin
    int         done;
    logic [2:0] fn;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    offer(FUNC_SET_POS, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    offer(FUNC_SET_VEL, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'd0);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'h7fff_ffff);
    offer(FUNC_SET_POS, 32'sd0, 32'sd0, 31'd0);
    offer(FUNC_SET_VEL, 32'sd65536, -32'sd65536, 31'd0);
    offer(FUNC_FORCE, 32'sd655360, -32'sd655360, 31'd0);
    offer(FUNC_GRAVITY, 32'sd0, 32'sd642253, 31'd0);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'd65536);
    offer(FUNC_FORCE, 32'sh8000_0000, 32'sh7fff_ffff, 31'd0);
    offer(FUNC_GRAVITY, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    offer(FUNC_GRAVITY, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'd32768);
    offer(FUNC_UNUSED_LO, -32'sd1, -32'sd1, 31'h7fff_ffff);
    offer(FUNC_UNUSED_LO + 3'd1, 32'sh7fff_ffff, 32'sh8000_0000, 31'd65536);
    offer(FUNC_UNUSED_HI, 32'sh8000_0000, 32'sh7fff_ffff, 31'd0);
    offer(FUNC_FORCE, -32'sd1, 32'sd1, 31'h7fff_ffff);
    offer(FUNC_SET_POS, 32'sd0, 32'sd65536001, 31'd0);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'd0);
    offer(FUNC_STEP, 32'sd0, 32'sd0, 31'd65536);
    offer(FUNC_SET_POS, -32'sd1, -32'sd1, 31'd0);

    for (int k = 0; k < 8; k++) begin
      settle();
      apply_phase(k);
      case (k % 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // long receiver hold-off so the block backs up onto its input
      if (k == 2) hold_len = 300;
      done = 0;
      while (done < PHASE_ITEMS) begin
        fn = rand_func();
        offer(fn, rand_value(), rand_value(), rand_step());
        if (fn <= FUNC_SET_VEL) done++;
      end
    end

    in_valid <= 1'b0;
    while (motion.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (motion.errors == 0) begin
      $display("tb_rigid_body_euler_integrator: clean");
    end else begin
      $display("tb_rigid_body_euler_integrator: errors");
    end
    $finish;
  end

endmodule
